[rtl/bti_pkg.sv]
// Shared constants, types and helpers of the bracket tape machine interpreter.
package bti_pkg;

  localparam int PROGRAM_DEPTH = 1024;
  localparam int TAPE_DEPTH    = 1024;
  localparam int INPUT_DEPTH   = 16;

  localparam int PROG_AW = $clog2(PROGRAM_DEPTH);
  localparam int PC_W    = $clog2(PROGRAM_DEPTH + 2);
  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int TLEN_W  = $clog2(TAPE_DEPTH + 1);
  localparam int Q_AW    = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(INPUT_DEPTH + 1);
  localparam int TS_W    = 11;
  localparam int SZ_W    = (TS_W > TLEN_W) ? TS_W : TLEN_W;

  typedef enum logic [1:0] {
    OPN_LOAD    = 2'd0,
    OPN_PUSH    = 2'd1,
    OPN_STEP    = 2'd2,
    OPN_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FIN    = 3'd1,
    ST_SYNTAX = 3'd2,
    ST_PTR    = 3'd3,
    ST_VALUE  = 3'd4,
    ST_EMPTY  = 3'd5,
    ST_BUSY   = 3'd6
  } status_t;

  // Error phases share their code with the status they report.
  typedef enum logic [2:0] {
    PH_LOAD   = 3'd0,
    PH_FIN    = 3'd1,
    PH_SYNTAX = 3'd2,
    PH_PTR    = 3'd3,
    PH_VALUE  = 3'd4,
    PH_RUN    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    C_RIGHT = 3'd0,
    C_LEFT  = 3'd1,
    C_INC   = 3'd2,
    C_DEC   = 3'd3,
    C_OUT   = 3'd4,
    C_IN    = 3'd5,
    C_OPEN  = 3'd6,
    C_CLOSE = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SREAD,
    S_SCHK
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic scan_mode;
    logic scan_chk;
    logic clr_en;
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic scan_go;
    logic scan_end;
    logic clr_last;
    logic hold;
  } dp_stat_t;

  // Bit 3 flags a command character, bits 2:0 give its code.
  function automatic logic [3:0] cmd_code(input logic [7:0] ch);
    logic [3:0] r;
    case (ch)
      8'h3E:   r = {1'b1, C_RIGHT};
      8'h3C:   r = {1'b1, C_LEFT};
      8'h2B:   r = {1'b1, C_INC};
      8'h2D:   r = {1'b1, C_DEC};
      8'h2E:   r = {1'b1, C_OUT};
      8'h2C:   r = {1'b1, C_IN};
      8'h5B:   r = {1'b1, C_OPEN};
      8'h5D:   r = {1'b1, C_CLOSE};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/bti_ctrl.sv]
// Controller state machine: sequences clear sweep, execute and bracket scan.
module bti_ctrl import bti_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait while the result slot is still occupied
        if (!stat.hold) begin
          cmd.exec = 1'b1;
          if (stat.restart) begin
            state_next = S_CLEAR;
          end else if (stat.scan_go) begin
            state_next = S_SREAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SREAD: begin
        cmd.scan_mode = 1'b1;
        state_next    = S_SCHK;
      end
      S_SCHK: begin
        cmd.scan_mode = 1'b1;
        if (!stat.hold) begin
          cmd.scan_chk = 1'b1;
          state_next   = stat.scan_end ? S_IDLE : S_SREAD;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

[rtl/bti_dpath.sv]
// Datapath: program, tape and input memories, machine registers, result slot.
module bti_dpath import bti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [1:0]         operation,
  input  logic [7:0]         program_char,
  input  logic               last_char,
  input  logic signed [15:0] read_value,
  input  logic               cfg_wr,
  input  logic [TS_W-1:0]    tape_size,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output status_t            status
);

  // captured item
  op_t         op_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic [15:0] val_q;

  logic [TS_W-1:0]    tsize;
  logic [PC_W-1:0]    plen, plen_next;
  logic [PC_W-1:0]    bal, bal_next;
  logic               sbad, sbad_next;
  logic [PC_W-1:0]    pc, pc_next;
  logic [TAPE_AW-1:0] ptr, ptr_next;
  logic [Q_AW-1:0]    head, head_next, tail, tail_next;
  logic [QCNT_W-1:0]  qcnt, qcnt_next;
  phase_t             phase, phase_next;
  logic [TAPE_AW-1:0] clr_addr, clr_addr_next;
  logic [PC_W-1:0]    scan_addr, scan_addr_next;
  logic [PC_W-1:0]    skip, skip_next;
  logic               scan_fwd, scan_fwd_next;

  logic [2:0] prog [PROGRAM_DEPTH];
  logic [7:0] tape [TAPE_DEPTH];
  logic [15:0] queue [INPUT_DEPTH];
  logic [2:0]  prog_rd;
  logic [7:0]  tape_rd;
  logic [15:0] q_rd;

  logic               pw_en;
  logic               tw_en;
  logic [TAPE_AW-1:0] tw_addr;
  logic [7:0]         tw_data;
  logic               qw_en;

  logic    res_ld, rv_n;
  logic [7:0] rb_n;
  status_t rs_n;

  logic [3:0]      code;
  logic [SZ_W-1:0] live;
  logic [PC_W-1:0] match;
  logic [PC_W-1:0] pc_inc;
  logic            scan_go, scan_end, step_live;
  status_t         st;

  assign stat.restart  = (op_q == OPN_RESTART);
  assign stat.scan_go  = scan_go;
  assign stat.scan_end = scan_end;
  assign stat.clr_last = (clr_addr == TAPE_AW'(TAPE_DEPTH - 1));
  assign stat.hold     = result_valid && !result_ready;

  assign code = cmd_code(char_q);

  always_comb begin
    if (tsize == '0) begin
      live = SZ_W'(1);
    end else if (SZ_W'(tsize) > SZ_W'(TAPE_DEPTH)) begin
      live = SZ_W'(TAPE_DEPTH);
    end else begin
      live = SZ_W'(tsize);
    end
  end

  // bracket instruction that needs a scan of the program
  assign step_live = (op_q == OPN_STEP) && (phase == PH_RUN) && (pc < plen);
  assign scan_go = step_live &&
                   (((prog_rd == C_OPEN) && (tape_rd == 8'd0)) ||
                    ((prog_rd == C_CLOSE) && (tape_rd != 8'd0) && (pc != '0)));

  always_comb begin
    scan_end = 1'b0;
    match    = plen;
    if (scan_fwd) begin
      if (scan_addr >= plen) begin
        scan_end = 1'b1;
      end else if ((prog_rd == C_CLOSE) && (skip == '0)) begin
        scan_end = 1'b1;
        match    = scan_addr;
      end
    end else begin
      if ((prog_rd == C_OPEN) && (skip == '0)) begin
        scan_end = 1'b1;
        match    = scan_addr;
      end else if (scan_addr == '0) begin
        scan_end = 1'b1;
      end
    end
  end

  always_comb begin
    plen_next      = plen;
    bal_next       = bal;
    sbad_next      = sbad;
    pc_next        = pc;
    ptr_next       = ptr;
    head_next      = head;
    tail_next      = tail;
    qcnt_next      = qcnt;
    phase_next     = phase;
    clr_addr_next  = clr_addr;
    scan_addr_next = scan_addr;
    skip_next      = skip;
    scan_fwd_next  = scan_fwd;
    pw_en   = 1'b0;
    tw_en   = 1'b0;
    tw_addr = ptr;
    tw_data = 8'd0;
    qw_en   = 1'b0;
    res_ld  = 1'b0;
    rv_n    = 1'b0;
    rb_n    = 8'd0;
    rs_n    = ST_OK;
    st      = ST_OK;
    pc_inc  = pc + PC_W'(1);

    if (cmd.clr_en) begin
      tw_en         = 1'b1;
      tw_addr       = clr_addr;
      clr_addr_next = clr_addr + TAPE_AW'(1);
    end

    if (cmd.exec) begin
      res_ld = !scan_go;
      case (op_q)
        OPN_LOAD: begin
          if (phase != PH_LOAD) begin
            st = ST_BUSY;
          end else begin
            if (code[3]) begin
              if (plen >= PC_W'(PROGRAM_DEPTH)) begin
                st = ST_BUSY;
              end else begin
                pw_en     = 1'b1;
                plen_next = plen + PC_W'(1);
                if (code[2:0] == C_OPEN) begin
                  bal_next = bal + PC_W'(1);
                end else if (code[2:0] == C_CLOSE) begin
                  if (bal == '0) begin
                    sbad_next = 1'b1;
                  end else begin
                    bal_next = bal - PC_W'(1);
                  end
                end
              end
            end
            if (last_q) begin
              if (sbad_next || (bal_next != '0)) begin
                phase_next = PH_SYNTAX;
                st         = ST_SYNTAX;
              end else if (plen_next == '0) begin
                phase_next = PH_FIN;
                st         = (st == ST_BUSY) ? ST_BUSY : ST_FIN;
              end else begin
                phase_next = PH_RUN;
              end
            end
          end
          rs_n = st;
        end
        OPN_PUSH: begin
          if (qcnt >= QCNT_W'(INPUT_DEPTH)) begin
            rs_n = ST_BUSY;
          end else begin
            qw_en     = 1'b1;
            tail_next = (tail == Q_AW'(INPUT_DEPTH - 1)) ? '0 : tail + Q_AW'(1);
            qcnt_next = qcnt + QCNT_W'(1);
          end
        end
        OPN_STEP: begin
          if (phase == PH_LOAD) begin
            rs_n = ST_BUSY;
          end else if (phase != PH_RUN) begin
            rs_n = status_t'(phase);
          end else if (pc >= plen) begin
            phase_next = PH_FIN;
            rs_n       = ST_FIN;
          end else begin
            st = ST_OK;
            case (cmd_t'(prog_rd))
              C_RIGHT: begin
                if (SZ_W'(ptr) + SZ_W'(1) >= live) begin
                  st = ST_PTR;
                end else begin
                  ptr_next = ptr + TAPE_AW'(1);
                end
              end
              C_LEFT: begin
                if (ptr == '0) begin
                  st = ST_PTR;
                end else begin
                  ptr_next = ptr - TAPE_AW'(1);
                end
              end
              C_INC: begin
                if (tape_rd == 8'd255) begin
                  st = ST_VALUE;
                end else begin
                  tw_en   = 1'b1;
                  tw_data = tape_rd + 8'd1;
                end
              end
              C_DEC: begin
                if (tape_rd == 8'd0) begin
                  st = ST_VALUE;
                end else begin
                  tw_en   = 1'b1;
                  tw_data = tape_rd - 8'd1;
                end
              end
              C_OUT: begin
                rv_n = 1'b1;
                rb_n = tape_rd;
              end
              C_IN: begin
                if (qcnt == '0) begin
                  st = ST_EMPTY;
                end else begin
                  head_next = (head == Q_AW'(INPUT_DEPTH - 1)) ? '0 : head + Q_AW'(1);
                  qcnt_next = qcnt - QCNT_W'(1);
                  if (q_rd > 16'd255) begin
                    st = ST_VALUE;
                  end else begin
                    tw_en   = 1'b1;
                    tw_data = q_rd[7:0];
                  end
                end
              end
              C_OPEN: begin
                scan_addr_next = pc + PC_W'(1);
              end
              C_CLOSE: begin
                if (tape_rd != 8'd0) begin
                  // no opener before the first instruction: run ends
                  pc_inc         = plen + PC_W'(1);
                  scan_addr_next = pc - PC_W'(1);
                end
              end
              default: begin
                st = ST_OK;
              end
            endcase
            skip_next     = '0;
            scan_fwd_next = (prog_rd == C_OPEN);
            if (st == ST_PTR) begin
              phase_next = PH_PTR;
              rs_n       = ST_PTR;
            end else if (st == ST_VALUE) begin
              phase_next = PH_VALUE;
              rs_n       = ST_VALUE;
            end else if (st == ST_EMPTY) begin
              rs_n = ST_EMPTY;
            end else if (!scan_go) begin
              pc_next = pc_inc;
              if (pc_inc >= plen) begin
                phase_next = PH_FIN;
                rs_n       = ST_FIN;
              end
            end
          end
        end
        OPN_RESTART: begin
          plen_next     = '0;
          bal_next      = '0;
          sbad_next     = 1'b0;
          pc_next       = '0;
          ptr_next      = '0;
          head_next     = '0;
          tail_next     = '0;
          qcnt_next     = '0;
          phase_next    = PH_LOAD;
          clr_addr_next = '0;
        end
        default: begin
          rs_n = ST_OK;
        end
      endcase
    end

    if (cmd.scan_chk) begin
      if (scan_end) begin
        res_ld  = 1'b1;
        pc_inc  = match + PC_W'(1);
        pc_next = pc_inc;
        if (pc_inc >= plen) begin
          phase_next = PH_FIN;
          rs_n       = ST_FIN;
        end
      end else if (scan_fwd) begin
        if (prog_rd == C_OPEN) begin
          skip_next = skip + PC_W'(1);
        end else if (prog_rd == C_CLOSE) begin
          skip_next = skip - PC_W'(1);
        end
        scan_addr_next = scan_addr + PC_W'(1);
      end else begin
        if (prog_rd == C_CLOSE) begin
          skip_next = skip + PC_W'(1);
        end else if (prog_rd == C_OPEN) begin
          skip_next = skip - PC_W'(1);
        end
        scan_addr_next = scan_addr - PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(operation);
      char_q <= program_char;
      last_q <= last_char;
      val_q  <= read_value;
    end
    scan_addr <= scan_addr_next;
    skip      <= skip_next;
    scan_fwd  <= scan_fwd_next;
    if (res_ld) begin
      out_valid <= rv_n;
      out_byte  <= rb_n;
      status    <= rs_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tsize        <= TS_W'(1024);
      plen         <= '0;
      bal          <= '0;
      sbad         <= 1'b0;
      pc           <= '0;
      ptr          <= '0;
      head         <= '0;
      tail         <= '0;
      qcnt         <= '0;
      phase        <= PH_LOAD;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        tsize <= tape_size;
      end
      plen     <= plen_next;
      bal      <= bal_next;
      sbad     <= sbad_next;
      pc       <= pc_next;
      ptr      <= ptr_next;
      head     <= head_next;
      tail     <= tail_next;
      qcnt     <= qcnt_next;
      phase    <= phase_next;
      clr_addr <= clr_addr_next;
      if (res_ld) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (pw_en) begin
      prog[plen[PROG_AW-1:0]] <= code[2:0];
    end
    prog_rd <= prog[cmd.scan_mode ? scan_addr[PROG_AW-1:0] : pc[PROG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      tape[tw_addr] <= tw_data;
    end
    tape_rd <= tape[ptr];
  end

  always_ff @(posedge clk) begin
    if (qw_en) begin
      queue[tail] <= val_q;
    end
    q_rd <= queue[head];
  end

  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= PC_W'(PROGRAM_DEPTH))
    else $error("program length beyond store depth");

  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= QCNT_W'(INPUT_DEPTH))
    else $error("input queue count beyond depth");

  a_run_balanced: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RUN) |-> ((bal == '0) && !sbad && (plen != '0)))
    else $error("running with an unbalanced or empty program");

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    res_ld |-> (!result_valid || result_ready))
    else $error("result overwritten before transaction");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (op_q == OPN_RESTART)) |=> ((phase == PH_LOAD) && (qcnt == '0)))
    else $error("restart left state behind");

endmodule

[rtl/bracket_tape_machine_interpreter_unit.sv]
// Top level of the bracket tape machine interpreter.
//
// Input channel (in_valid/in_ready) carries one item per transaction:
// operation selects load program char, push input value, execute one
// step, or restart. Every item yields exactly one result transaction on
// result_valid/result_ready with out_valid, out_byte and status.
// tape_size is written through cfg_valid/cfg_ready (always ready).
//
// result_valid is registered and rises once the item has executed in the
// EXEC state; in_ready returns in the same cycle. A bracket jump scans
// the program entry by entry before its result, with one program memory
// read (S_SREAD) and one compare (S_SCHK) per entry.
// After reset and after a restart item the tape is swept to zero, one cell
// per cycle, with in_ready low until all TAPE_DEPTH (1024) cells are clear.
// While the receiver stalls, one result waits in the output register and
// the next item is still taken; its result is held back until the slot
// frees.
module bracket_tape_machine_interpreter_unit import bti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         program_char,
  input  logic               last_char,
  input  logic signed [15:0] read_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TS_W-1:0]    tape_size,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic [2:0]         status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  status_t  status_q;

  assign cfg_ready = 1'b1;
  assign status    = status_q;

  bti_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bti_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .program_char (program_char),
    .last_char    (last_char),
    .read_value   (read_value),
    .cfg_wr       (cfg_valid && cfg_ready),
    .tape_size    (tape_size),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .status       (status_q)
  );

endmodule

[bench/bracket_tape_machine_interpreter_unit_checker.sv]
// Result checker: watches the item and result channels, predicts each result and compares.
`timescale 1ns / 100ps
module bracket_tape_machine_interpreter_unit_checker import bti_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         program_char,
  input  logic               last_char,
  input  logic signed [15:0] read_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [TS_W-1:0]    tape_size,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic               out_valid,
  input  logic [7:0]         out_byte,
  input  logic [2:0]         status,
  output int                 fail_count,
  output int                 pending,
  output int                 out_seen,
  output int                 err_seen
);

  typedef struct packed {
    logic       ov;
    logic [7:0] ob;
    logic [2:0] st;
  } outcome_t;

  outcome_t outcome_q[$];

  logic [2:0]  prog_mem[PROGRAM_DEPTH];
  int          prog_len, balance, pc, ptr;
  logic        unbalanced;
  logic [7:0]  tape[TAPE_DEPTH];
  logic [15:0] rd_fifo[$];
  phase_t      phase;
  logic [10:0] size_reg;

  function automatic void wipe_machine();
    for (int i = 0; i < TAPE_DEPTH; i++) tape[i] = '0;
    rd_fifo.delete();
    prog_len = 0; balance = 0; pc = 0; ptr = 0; unbalanced = 0;
    phase = PH_LOAD;
  endfunction

  function automatic int usable_cells();
    if (size_reg == 0) return 1;
    if (size_reg > TAPE_DEPTH) return TAPE_DEPTH;
    return size_reg;
  endfunction

  function automatic int find_partner(int from, bit fwd);
    int depth;
    depth = 0;
    if (fwd) begin
      for (int i = from + 1; i < prog_len; i++) begin
        if (prog_mem[i] == C_OPEN) depth++;
        else if (prog_mem[i] == C_CLOSE) begin
          if (depth == 0) return i;
          depth--;
        end
      end
    end else begin
      for (int i = from - 1; i >= 0; i--) begin
        if (prog_mem[i] == C_CLOSE) depth++;
        else if (prog_mem[i] == C_OPEN) begin
          if (depth == 0) return i;
          depth--;
        end
      end
    end
    return prog_len;
  endfunction

  function automatic outcome_t load_char(logic [7:0] ch, logic last);
    outcome_t r;
    int code;
    r = '0;
    r.st = ST_OK;
    if (phase != PH_LOAD) begin
      r.st = ST_BUSY;
      return r;
    end
    case (ch)
      ">": code = C_RIGHT;
      "<": code = C_LEFT;
      "+": code = C_INC;
      "-": code = C_DEC;
      ".": code = C_OUT;
      ",": code = C_IN;
      "[": code = C_OPEN;
      "]": code = C_CLOSE;
      default: code = -1;
    endcase
    if (code >= 0) begin
      if (prog_len >= PROGRAM_DEPTH) r.st = ST_BUSY;
      else begin
        prog_mem[prog_len] = code[2:0];
        prog_len++;
        if (code == C_OPEN) balance++;
        else if (code == C_CLOSE) begin
          if (balance == 0) unbalanced = 1;
          else balance--;
        end
      end
    end
    if (last) begin
      if (unbalanced || balance != 0) begin
        phase = PH_SYNTAX;
        r.st = ST_SYNTAX;
      end else if (prog_len == 0) begin
        phase = PH_FIN;
        if (r.st != ST_BUSY) r.st = ST_FIN;
      end else phase = PH_RUN;
    end
    return r;
  endfunction

  function automatic outcome_t run_one();
    outcome_t r;
    logic [7:0] cur;
    logic [15:0] v;
    r = '0;
    if (phase == PH_LOAD) begin r.st = ST_BUSY; return r; end
    if (phase != PH_RUN) begin r.st = phase; return r; end
    if (pc >= prog_len) begin phase = PH_FIN; r.st = ST_FIN; return r; end
    cur = tape[ptr];
    case (cmd_t'(prog_mem[pc]))
      C_RIGHT: begin
        if (ptr + 1 >= usable_cells()) begin phase = PH_PTR; r.st = ST_PTR; return r; end
        ptr++;
      end
      C_LEFT: begin
        if (ptr == 0) begin phase = PH_PTR; r.st = ST_PTR; return r; end
        ptr--;
      end
      C_INC: begin
        if (cur == 8'd255) begin phase = PH_VALUE; r.st = ST_VALUE; return r; end
        tape[ptr] = cur + 8'd1;
      end
      C_DEC: begin
        if (cur == 8'd0) begin phase = PH_VALUE; r.st = ST_VALUE; return r; end
        tape[ptr] = cur - 8'd1;
      end
      C_OUT: begin
        r.ov = 1;
        r.ob = cur;
      end
      C_IN: begin
        if (rd_fifo.size() == 0) begin r.st = ST_EMPTY; return r; end
        v = rd_fifo.pop_front();
        if (v > 16'd255) begin phase = PH_VALUE; r.st = ST_VALUE; return r; end
        tape[ptr] = v[7:0];
      end
      C_OPEN: if (cur == 0) pc = find_partner(pc, 1);
      default: if (cur != 0) pc = find_partner(pc, 0);
    endcase
    pc++;
    if (pc >= prog_len) begin phase = PH_FIN; r.st = ST_FIN; end
    else r.st = ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want, got;
    if (rst) begin
      wipe_machine();
      size_reg <= 11'd1024;
      outcome_q.delete();
      fail_count <= 0;
      pending <= 0;
      out_seen <= 0;
      err_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) size_reg <= tape_size;
      if (in_valid && in_ready) begin
        case (op_t'(operation))
          OPN_LOAD: want = load_char(program_char, last_char);
          OPN_PUSH: begin
            want = '0;
            if (rd_fifo.size() >= INPUT_DEPTH) want.st = ST_BUSY;
            else rd_fifo.push_back(read_value);
          end
          OPN_STEP: want = run_one();
          default: begin
            wipe_machine();
            want = '0;
          end
        endcase
        outcome_q.push_back(want);
      end
      if (result_valid && result_ready) begin
        got = {out_valid, out_byte, status};
        if (got.ov) out_seen <= out_seen + 1;
        if (got.st >= ST_SYNTAX) err_seen <= err_seen + 1;
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result ov=%0d byte=%0d status=%0d",
                   $time, got.ov, got.ob, got.st);
          fail_count <= fail_count + 1;
        end else begin
          want = outcome_q.pop_front();
          if (want !== got) begin
            $display({"%0t: mismatch expected ov=%0d byte=%0d status=%0d,",
                      " got ov=%0d byte=%0d status=%0d"},
                     $time, want.ov, want.ob, want.st, got.ov, got.ob, got.st);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= outcome_q.size();
    end
  end

endmodule

[bench/bracket_tape_machine_interpreter_unit_tb.sv]
// Testbench top: drives programs, input values and steps, and reports the verdict.
`timescale 1ns / 100ps
module bracket_tape_machine_interpreter_unit_tb;
  import bti_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         operation = OPN_RESTART;
  logic [7:0]         program_char = '0;
  logic               last_char = 0;
  logic signed [15:0] read_value = '0;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [TS_W-1:0]    tape_size = 11'd1024;
  logic               result_valid;
  logic               result_ready = 0;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic [2:0]         status;
  int                 fail_count, pending, out_seen, err_seen;
  int                 items_sent = 0;
  int                 idle_cycles = 0;
  bit                 rx_quiet = 0;

  always #5 clk = ~clk;

  bracket_tape_machine_interpreter_unit uut (.*);

  bracket_tape_machine_interpreter_unit_checker chk (.*);

  // Watchdog: cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired at %0t", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall before each result, with quiet stretches.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        result_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // Valid is left high after a transaction; the next item or an idle drops it.
  task automatic send_item(op_t op, logic [7:0] ch, logic last, logic [15:0] val);
    int gap;
    gap = rx_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1;
    operation    <= op;
    program_char <= ch;
    last_char    <= last;
    read_value   <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [10:0] sz);
    drain_results();
    cfg_valid <= 1;
    tape_size <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(OPN_LOAD, s[i], i == s.len() - 1, 16'($urandom));
  endtask

  task automatic step_n(int n);
    repeat (n) send_item(OPN_STEP, 8'($urandom), 1'($urandom), 16'($urandom));
  endtask

  function automatic byte pick_cmd(bit with_brackets);
    string cs;
    cs = with_brackets ? "><+-.,[]" : "><+-.,";
    return cs[$urandom_range(0, cs.len() - 1)];
  endfunction

  // Random program, mostly balanced, with some noise and broken sequences.
  task automatic random_program();
    int n, depth;
    byte c;
    bit broken;
    n = $urandom_range(1, 14);
    depth = 0;
    broken = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: c = 8'($urandom);
        1: begin c = "["; depth++; end
        2: if (depth > 0 || broken) begin c = "]"; depth--; end else c = "+";
        3, 4: c = "+";
        default: c = pick_cmd(0);
      endcase
      send_item(OPN_LOAD, c, 0, 16'($urandom));
    end
    while (depth > 0 && !broken) begin
      send_item(OPN_LOAD, "]", 0, 16'($urandom));
      depth--;
    end
    send_item(OPN_LOAD, $urandom_range(0, 1) ? "." : pick_cmd(1), 1, 16'($urandom));
  endtask

  initial begin
    int runs;
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: syntax, empty program, extremes, loads after the program is closed.
    load_text("]+[]");
    step_n(1);
    send_item(OPN_LOAD, "+", 1, 0);
    send_item(OPN_RESTART, 8'hFF, 1, 16'hFFFF);
    send_item(OPN_STEP, 0, 0, 0);
    send_item(OPN_LOAD, 8'h00, 1, 0);
    step_n(1);
    send_item(OPN_RESTART, 0, 0, 0);
    send_item(OPN_PUSH, 0, 0, 16'h8000);
    send_item(OPN_PUSH, 0, 0, 16'h00FF);
    send_item(OPN_PUSH, 0, 0, 16'h7FFF);
    load_text(",.,.-<");
    step_n(6);
    send_item(OPN_RESTART, 0, 0, 0);
    load_text("+[->+<]>.>");
    write_size(11'd0);
    step_n(12);
    send_item(OPN_RESTART, 0, 0, 0);
    write_size(11'd2047);
    repeat (17) send_item(OPN_PUSH, 0, 0, 16'($urandom_range(0, 255)));
    load_text("-,.");
    step_n(4);
    send_item(OPN_RESTART, 0, 0, 0);
    load_text("[");
    step_n(1);
    write_size(11'd3);

    // Random programs with random runs of steps, pushes and restarts.
    runs = 0;
    while (items_sent < 950) begin
      if (runs % 12 == 11)
        write_size($urandom_range(0, 3) == 0 ? 11'd1 :
                   ($urandom_range(0, 1) ? 11'd1024 : 11'($urandom_range(1, 2047))));
      rx_quiet = ($urandom_range(0, 4) == 0);
      send_item(OPN_RESTART, 8'($urandom), 1'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 6))
        send_item(OPN_PUSH, 8'($urandom), 1'($urandom),
                  16'($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 255)));
      random_program();
      repeat ($urandom_range(10, 40)) begin
        case ($urandom_range(0, 19))
          0: send_item(OPN_PUSH, 8'($urandom), 1'($urandom), 16'($urandom_range(0, 255)));
          1: send_item(OPN_LOAD, 8'($urandom), 1'($urandom), 16'($urandom));
          default: step_n(1);
        endcase
      end
      if (runs % 20 == 5) drain_results();
      runs++;
    end
    rx_quiet = 0;

    drain_results();
    repeat (50) @(posedge clk);
    $display("Ran %0d items over %0d random programs; %0d output bytes, %0d error results.",
             items_sent, runs, out_seen, err_seen);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
